// ===== hw/rtl/bia_pkg.sv =====
// Shared types and codes for the bitmap identifier allocator.
package bia_pkg;

   localparam int ID_W      = 8;
   localparam int ID_BASE_W = ID_W + 1;
   localparam int ID_LIMIT  = 256;

   typedef logic [ID_W-1:0]      id_type;
   typedef logic [ID_BASE_W-1:0] id_base_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

endpackage

// ===== hw/rtl/bia_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
module bia_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bitmap_id_allocator_top.sv =====
// Top level of the bitmap identifier allocator.
//
// Hands out the lowest free identifier on an allocate transaction and releases
// a given identifier on a free transaction; every request yields one response.
// Identifiers run from 0 to min(NUM_WORDS*WORD_BITS, 256)-1 and are kept as
// one bit each in a RAM of WORD_BITS-wide words, read one word per cycle.
// An allocate reads words from word 0 until one with a clear bit is found
// (all used words if the store is full); a free steps to the word holding
// the identifier and then clears its bit; an out-of-range free is answered
// straight from idle. Requests are handled one at a time and a new one
// is taken once the previous response has been accepted. A valid flag per
// word stands in for clearing the RAM, so the store is usable right after
// reset.
module bitmap_id_allocator_top
   import bia_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int NUM_WORDS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] free_id
   input  logic [0:0]  req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] granted_id, [9:8] status, [15:10] zero
   output logic [0:0]  rsp_tuser    // [0] was_free_op
);

   localparam int TOTAL     = NUM_WORDS * WORD_BITS;
   localparam int CAP       = (TOTAL > ID_LIMIT) ? ID_LIMIT : TOTAL;
   localparam int USED      = (CAP + WORD_BITS - 1) / WORD_BITS;
   localparam int LAST      = USED - 1;
   localparam int LAST_BITS = CAP - LAST * WORD_BITS;
   localparam int AW        = (USED > 1) ? $clog2(USED) : 1;
   localparam int BW        = $clog2(WORD_BITS);

   localparam logic [AW-1:0]        LAST_W    = AW'(LAST);
   localparam id_base_type          CAP_V     = ID_BASE_W'(CAP);
   localparam id_base_type          WORD_STEP = ID_BASE_W'(WORD_BITS);
   localparam logic [WORD_BITS-1:0] WORD_ONE  = {{(WORD_BITS-1){1'b0}}, 1'b1};

   typedef enum logic [1:0] {
      S_IDLE,
      S_ALLOC_CHK,
      S_FREE_SEEK,
      S_FREE_MOD
   } state_type;

   state_type      state_ff, state_in;
   logic [AW-1:0]  word_ff, word_in;
   id_base_type    base_ff, base_in;
   id_type         fid_ff, fid_in;
   logic [USED-1:0] valid_ff, valid_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_kind_ff, rsp_kind_in;
   id_type         rsp_id_ff, rsp_id_in;
   status_type     rsp_status_ff, rsp_status_in;

   logic                 req_accept;
   logic                 wr_en;
   logic [AW-1:0]        rd_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS-1:0] rd_data;
   logic [WORD_BITS-1:0] word_data;
   logic [WORD_BITS-1:0] tail_mask;
   logic [WORD_BITS-1:0] alloc_view;
   logic                 zero_found;
   logic [BW-1:0]        zero_pos;
   id_base_type          grant_sum;
   id_base_type          free_off;
   id_base_type          base_next;

   bia_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (USED),
      .AW    (AW)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_accept = req_tvalid && req_tready;

   assign word_data = valid_ff[word_ff] ? rd_data : '0;
   assign base_next = base_ff + WORD_STEP;
   assign grant_sum = base_ff + ID_BASE_W'(zero_pos);
   assign free_off  = {1'b0, fid_ff} - base_ff;

   // bits past the last identifier read as taken
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         tail_mask[b] = (word_ff == LAST_W) && (b >= LAST_BITS);
      end
   end

   assign alloc_view = word_data | tail_mask;
   assign zero_found = ~&alloc_view;

   always_comb begin
      zero_pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!alloc_view[b]) begin
            zero_pos = BW'(b);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      base_in       = base_ff;
      fid_in        = fid_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_data       = word_data | (WORD_ONE << zero_pos);
      rd_addr       = word_ff;

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (req_accept) begin
               word_in = '0;
               base_in = '0;
               fid_in  = req_tdata;
               if (req_tuser[0] == OP_ALLOC) begin
                  state_in = S_ALLOC_CHK;
               end else if ({1'b0, req_tdata} >= CAP_V) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = OP_FREE;
                  rsp_id_in     = '0;
                  rsp_status_in = ST_RANGE;
               end else begin
                  state_in = S_FREE_SEEK;
               end
            end
         end
         S_ALLOC_CHK: begin
            rd_addr = (word_ff == LAST_W) ? word_ff : word_ff + AW'(1);
            if (zero_found) begin
               wr_en             = 1'b1;
               valid_in[word_ff] = 1'b1;
               rsp_valid_in      = 1'b1;
               rsp_kind_in       = OP_ALLOC;
               rsp_id_in         = grant_sum[ID_W-1:0];
               rsp_status_in     = ST_OK;
               state_in          = S_IDLE;
            end else if (word_ff == LAST_W) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = OP_ALLOC;
               rsp_id_in     = '0;
               rsp_status_in = ST_FULL;
               state_in      = S_IDLE;
            end else begin
               word_in = word_ff + AW'(1);
               base_in = base_next;
            end
         end
         S_FREE_SEEK: begin
            if ({1'b0, fid_ff} < base_next) begin
               state_in = S_FREE_MOD;
            end else begin
               word_in = word_ff + AW'(1);
               base_in = base_next;
            end
         end
         S_FREE_MOD: begin
            wr_en             = 1'b1;
            wr_data           = word_data & ~(WORD_ONE << free_off[BW-1:0]);
            valid_in[word_ff] = 1'b1;
            rsp_valid_in      = 1'b1;
            rsp_kind_in       = OP_FREE;
            rsp_id_in         = '0;
            rsp_status_in     = ST_OK;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff       <= word_in;
      base_ff       <= base_in;
      fid_ff        <= fid_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_kind_ff;

endmodule

// ===== verif/bitmap_id_allocator_top_test.sv =====
// Self-checking testbench for bitmap_id_allocator_top: directed table, then random traffic.
module bitmap_id_allocator_top_test
   import bia_pkg::*;
();

   localparam int WORD_BITS    = 32;
   localparam int NUM_WORDS    = 8;
   localparam int CAPACITY     = (NUM_WORDS * WORD_BITS > ID_LIMIT) ? ID_LIMIT
                                                                    : NUM_WORDS * WORD_BITS;
   localparam int RANDOM_ITEMS = 1400;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 24;
   localparam int DIRECTED_N   = 22;

   typedef struct packed {
      op_type     op;
      id_type     granted;
      status_type status;
   } id_result_type;

   typedef struct packed {
      op_type        op;
      id_type        fid;
      logic          typed;
      id_result_type rsp;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] free_id
   logic [0:0]  req_tuser;   // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [7:0] granted_id, [9:8] status, [15:10] zero
   logic [0:0]  rsp_tuser;   // [0] was_free_op

   logic [WORD_BITS-1:0] id_in_use [NUM_WORDS];
   int                   held_count;
   id_result_type        pending_results [$];
   int                   fail_count;
   int                   quiet_cycles;
   int                   send_idle_pct;
   int                   recv_stall_pct;
   bit                   fill_mode;
   int                   full_hits;

   // typed rows: expectations read straight off reset state and lowest-free order
   directed_row_type directed_rows [DIRECTED_N] = '{
      '{OP_FREE,  8'd0,   1'b1, '{OP_FREE,  8'd0, ST_OK}},   // free of an idle id
      '{OP_FREE,  8'd255, 1'b1, '{OP_FREE,  8'd0, ST_OK}},
      '{OP_ALLOC, 8'd0,   1'b1, '{OP_ALLOC, 8'd0, ST_OK}},
      '{OP_ALLOC, 8'd0,   1'b1, '{OP_ALLOC, 8'd1, ST_OK}},
      '{OP_ALLOC, 8'd255, 1'b1, '{OP_ALLOC, 8'd2, ST_OK}},   // free_id ignored
      '{OP_FREE,  8'd1,   1'b1, '{OP_FREE,  8'd0, ST_OK}},
      '{OP_ALLOC, 8'd0,   1'b1, '{OP_ALLOC, 8'd1, ST_OK}},   // hole refilled first
      '{OP_FREE,  8'd1,   1'b1, '{OP_FREE,  8'd0, ST_OK}},
      '{OP_FREE,  8'd1,   1'b1, '{OP_FREE,  8'd0, ST_OK}},   // double free
      '{OP_ALLOC, 8'd255, 1'b1, '{OP_ALLOC, 8'd1, ST_OK}},
      '{OP_ALLOC, 8'd170, 1'b1, '{OP_ALLOC, 8'd3, ST_OK}},
      '{OP_FREE,  8'd170, 1'b1, '{OP_FREE,  8'd0, ST_OK}},
      '{OP_FREE,  8'd85,  1'b1, '{OP_FREE,  8'd0, ST_OK}},
      '{OP_FREE,  8'd2,   1'b1, '{OP_FREE,  8'd0, ST_OK}},
      '{OP_ALLOC, 8'd0,   1'b1, '{OP_ALLOC, 8'd2, ST_OK}},
      '{OP_ALLOC, 8'd0,   1'b1, '{OP_ALLOC, 8'd4, ST_OK}},
      '{OP_FREE,  8'd0,   1'b1, '{OP_FREE,  8'd0, ST_OK}},
      '{OP_ALLOC, 8'd0,   1'b0, '0},
      '{OP_ALLOC, 8'd128, 1'b0, '0},
      '{OP_FREE,  8'd5,   1'b0, '0},
      '{OP_FREE,  8'd4,   1'b0, '0},
      '{OP_ALLOC, 8'd127, 1'b0, '0}
   };

   bitmap_id_allocator_top #(
      .WORD_BITS (WORD_BITS),
      .NUM_WORDS (NUM_WORDS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic id_result_type apply_request(op_type op, id_type fid);
      id_result_type r;
      bit            found;
      int            w;
      int            b;
      r.op      = op;
      r.granted = '0;
      r.status  = ST_OK;
      if (op == OP_ALLOC) begin
         found = 1'b0;
         for (int n = 0; n < CAPACITY && !found; n++) begin
            w = n / WORD_BITS;
            b = n % WORD_BITS;
            if (!id_in_use[w][b]) begin
               id_in_use[w][b] = 1'b1;
               r.granted       = id_type'(n);
               found           = 1'b1;
               held_count++;
            end
         end
         if (!found) begin
            r.status = ST_FULL;
         end
      end else if (int'(fid) >= CAPACITY) begin
         r.status = ST_RANGE;
      end else begin
         w = int'(fid) / WORD_BITS;
         b = int'(fid) % WORD_BITS;
         if (id_in_use[w][b]) begin
            held_count--;
         end
         id_in_use[w][b] = 1'b0;
      end
      return r;
   endfunction

   function automatic id_type pick_held_id();
      int start;
      int n;
      start = $urandom_range(0, CAPACITY - 1);
      for (int k = 0; k < CAPACITY; k++) begin
         n = (start + k) % CAPACITY;
         if (id_in_use[n / WORD_BITS][n % WORD_BITS]) begin
            return id_type'(n);
         end
      end
      return id_type'(start);
   endfunction

   task automatic send_request(input op_type op, input id_type fid, input logic typed,
                               input id_result_type typed_rsp, output status_type got_status);
      id_result_type predicted;
      while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= fid;
      do @(posedge clock); while (!req_tready);
      predicted  = apply_request(op, fid);
      got_status = predicted.status;
      pending_results.push_back(typed ? typed_rsp : predicted);
   endtask

   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= !(recv_stall_pct > 0 && $urandom_range(1, 100) <= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      id_result_type want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL bitmap_id_allocator_top");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("response transaction with no request outstanding");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tuser[0] !== want.op) begin
                  $error("was_free_op: expected %0d, got %0d", want.op, rsp_tuser[0]);
                  fail_count++;
               end
               if (rsp_tdata[7:0] !== want.granted) begin
                  $error("granted_id: expected %0d, got %0d", want.granted, rsp_tdata[7:0]);
                  fail_count++;
               end
               if (rsp_tdata[9:8] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tdata[9:8]);
                  fail_count++;
               end
               if (rsp_tdata[15:10] !== 6'd0) begin
                  $error("pad: expected 0, got %0d", rsp_tdata[15:10]);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      op_type     op;
      id_type     fid;
      status_type got;
      reset          <= 1'b1;
      req_tvalid     <= 1'b0;
      req_tdata      <= '0;
      req_tuser      <= '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fail_count     = 0;
      quiet_cycles   = 0;
      fill_mode      = 1'b1;
      full_hits      = 0;
      held_count     = 0;
      for (int w = 0; w < NUM_WORDS; w++) begin
         id_in_use[w] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].op, directed_rows[i].fid, directed_rows[i].typed,
                      directed_rows[i].rsp, got);
      end

      // fill to exhaustion, sit on the full store a while, drain, repeat
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         unique case (i / (RANDOM_ITEMS / 4))
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         op = ($urandom_range(1, 100) <= (fill_mode ? 95 : 10)) ? OP_ALLOC : OP_FREE;
         if (op == OP_FREE && held_count > 0 && $urandom_range(1, 100) <= 80) begin
            fid = pick_held_id();
         end else begin
            fid = id_type'($urandom_range(0, 255));
         end
         send_request(op, fid, 1'b0, '0, got);
         if (got == ST_FULL) begin
            full_hits++;
         end
         if (fill_mode && full_hits >= 4) begin
            fill_mode = 1'b0;
            full_hits = 0;
         end else if (!fill_mode && held_count < 16) begin
            fill_mode = 1'b1;
         end
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS bitmap_id_allocator_top");
      end else begin
         $display("FAIL bitmap_id_allocator_top");
      end
      $finish;
   end

endmodule
